@@ design/assert_macros.svh @@
// Assertion helpers used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while the block is out of reset.
`define SFS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every clock edge, including during reset.
`define SFS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/sfs_pkg.sv @@
package sfs_pkg;

    localparam int TempW    = 9;
    localparam int VoltW    = 16;
    localparam int TimeW    = 16;
    localparam int CountW   = 16;
    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 16;
    localparam int InDataW  = 32;
    localparam int OutDataW = 8;

    localparam logic [CountW-1:0] COUNT_MAX = {CountW{1'b1}};

    typedef enum logic [2:0] {
        MODE_OFF    = 3'd0,
        MODE_ON     = 3'd1,
        MODE_BOTH   = 3'd2,
        MODE_OVERT  = 3'd3,
        MODE_UNDERV = 3'd4
    } led_mode_t;

    typedef enum logic [CfgIdxW-1:0] {
        REG_SUPPLY_REQUEST     = 3'd0,
        REG_TEMP_LIMIT         = 3'd1,
        REG_MIN_VOLTAGE_LIMIT  = 3'd2,
        REG_FAST_BLINK_TIME    = 3'd3,
        REG_OVERTEMP_ON_TIME   = 3'd4,
        REG_OVERTEMP_OFF_TIME  = 3'd5,
        REG_UNDERVOLT_ON_TIME  = 3'd6,
        REG_UNDERVOLT_OFF_TIME = 3'd7
    } cfg_index_t;

    localparam logic              RST_SUPPLY_REQUEST     = 1'b1;
    localparam logic [TempW-1:0]  RST_TEMP_LIMIT         = 9'd70;
    localparam logic [VoltW-1:0]  RST_MIN_VOLTAGE_LIMIT  = 16'd10;
    localparam logic [TimeW-1:0]  RST_FAST_BLINK_TIME    = 16'd100;
    localparam logic [TimeW-1:0]  RST_OVERTEMP_ON_TIME   = 16'd800;
    localparam logic [TimeW-1:0]  RST_OVERTEMP_OFF_TIME  = 16'd200;
    localparam logic [TimeW-1:0]  RST_UNDERVOLT_ON_TIME  = 16'd100;
    localparam logic [TimeW-1:0]  RST_UNDERVOLT_OFF_TIME = 16'd900;

    typedef struct packed {
        logic              supply_request;
        logic [TempW-1:0]  temp_limit;
        logic [VoltW-1:0]  min_voltage_limit;
        logic [TimeW-1:0]  fast_blink_time;
        logic [TimeW-1:0]  overtemp_on_time;
        logic [TimeW-1:0]  overtemp_off_time;
        logic [TimeW-1:0]  undervolt_on_time;
        logic [TimeW-1:0]  undervolt_off_time;
    } cfg_t;

    typedef struct packed {
        logic              over_temp;
        logic              under_volt;
        logic              supply_on;
        logic              led_level;
        logic [CountW-1:0] since_toggle;
    } state_t;

    typedef struct packed {
        logic      relay_on;
        logic      led_on;
        led_mode_t led_mode;
        logic      ot_fault;
        logic      uv_fault;
    } result_t;

endpackage

@@ design/sfs_cfg.sv @@
module sfs_cfg
    import sfs_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgDataW-1:0] cfg_data,
    output cfg_t                cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                REG_SUPPLY_REQUEST:     cfg_next.supply_request     = cfg_data[0];
                REG_TEMP_LIMIT:         cfg_next.temp_limit         = cfg_data[TempW-1:0];
                REG_MIN_VOLTAGE_LIMIT:  cfg_next.min_voltage_limit  = cfg_data[VoltW-1:0];
                REG_FAST_BLINK_TIME:    cfg_next.fast_blink_time    = cfg_data[TimeW-1:0];
                REG_OVERTEMP_ON_TIME:   cfg_next.overtemp_on_time   = cfg_data[TimeW-1:0];
                REG_OVERTEMP_OFF_TIME:  cfg_next.overtemp_off_time  = cfg_data[TimeW-1:0];
                REG_UNDERVOLT_ON_TIME:  cfg_next.undervolt_on_time  = cfg_data[TimeW-1:0];
                REG_UNDERVOLT_OFF_TIME: cfg_next.undervolt_off_time = cfg_data[TimeW-1:0];
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.supply_request     <= RST_SUPPLY_REQUEST;
            cfg_reg.temp_limit         <= RST_TEMP_LIMIT;
            cfg_reg.min_voltage_limit  <= RST_MIN_VOLTAGE_LIMIT;
            cfg_reg.fast_blink_time    <= RST_FAST_BLINK_TIME;
            cfg_reg.overtemp_on_time   <= RST_OVERTEMP_ON_TIME;
            cfg_reg.overtemp_off_time  <= RST_OVERTEMP_OFF_TIME;
            cfg_reg.undervolt_on_time  <= RST_UNDERVOLT_ON_TIME;
            cfg_reg.undervolt_off_time <= RST_UNDERVOLT_OFF_TIME;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ design/sfs_step.sv @@
module sfs_step
    import sfs_pkg::*;
(
    input  cfg_t             cfg,
    input  state_t           state,
    input  logic             kind,
    input  logic [TempW-1:0] temperature,
    input  logic [VoltW-1:0] min_cell_voltage,
    output state_t           state_next,
    output result_t          result
);

    logic              over_temp;
    logic              under_volt;
    logic [CountW-1:0] count;
    logic [TimeW-1:0]  limit;
    logic              led_level;
    logic [CountW-1:0] count_next;
    led_mode_t         mode;

    always_comb
    begin
        over_temp  = state.over_temp;
        under_volt = state.under_volt;
        count      = state.since_toggle;
        if (!kind)
        begin
            if (count != COUNT_MAX)
            begin
                count = count + CountW'(1);
            end
        end
        else
        begin
            over_temp  = $signed(temperature) > $signed(cfg.temp_limit);
            under_volt = min_cell_voltage < cfg.min_voltage_limit;
        end
    end

    always_comb
    begin
        if (state.supply_on)
        begin
            mode = MODE_ON;
        end
        else if (under_volt)
        begin
            mode = over_temp ? MODE_BOTH : MODE_UNDERV;
        end
        else
        begin
            mode = over_temp ? MODE_OVERT : MODE_OFF;
        end
    end

    always_comb
    begin
        case (mode)
            MODE_BOTH:   limit = cfg.fast_blink_time;
            MODE_OVERT:  limit = state.led_level ? cfg.overtemp_on_time : cfg.overtemp_off_time;
            MODE_UNDERV: limit = state.led_level ? cfg.undervolt_on_time
                                                 : cfg.undervolt_off_time;
            default:     limit = cfg.fast_blink_time;
        endcase
    end

    always_comb
    begin
        led_level  = state.led_level;
        count_next = count;
        case (mode)
            MODE_ON:
            begin
                led_level = 1'b1;
            end
            MODE_BOTH, MODE_OVERT, MODE_UNDERV:
            begin
                if (count > limit)
                begin
                    led_level  = ~state.led_level;
                    count_next = '0;
                end
            end
            default:
            begin
                led_level = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next.over_temp    = over_temp;
        state_next.under_volt   = under_volt;
        state_next.supply_on    = cfg.supply_request & ~over_temp & ~under_volt;
        state_next.led_level    = led_level;
        state_next.since_toggle = count_next;

        result.relay_on = state.supply_on;
        result.led_on   = led_level;
        result.led_mode = mode;
        result.ot_fault = over_temp;
        result.uv_fault = under_volt;
    end

endmodule

@@ design/supply_fault_supervisor_led.sv @@
// Channel     Direction  Payload
// s_axis      in         tuser: kind; tdata: temperature, min_cell_voltage
// m_axis      out        tdata: relay_on, led_on, led_mode, ot_fault, uv_fault
// cfg         in         cfg_we, cfg_index, cfg_data
//
// A request is held in the input register and its result in the output register.
// One new request is accepted every cycle while m_axis_tready is high.
// Reset puts the configuration registers to their package defaults, clears both valid flags
// and the supervisor state. A result held by a low m_axis_tready lets one more request wait in the input register.
`include "assert_macros.svh"

module supply_fault_supervisor_led
    import sfs_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [InDataW-1:0]  s_axis_tdata,   // temperature[8:0], min_cell_voltage[24:9]
    input  logic                s_axis_tuser,   // kind

    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [OutDataW-1:0] m_axis_tdata,   // relay_on, led_on, led_mode[2:0],
                                                // ot_fault, uv_fault

    input  logic                cfg_we,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgDataW-1:0] cfg_data
);

    cfg_t              cfg;
    state_t            state_reg;
    state_t            state_next;
    result_t           result;

    logic              in_valid_reg;
    logic              in_kind_reg;
    logic [TempW-1:0]  in_temp_reg;
    logic [VoltW-1:0]  in_volt_reg;
    logic              out_valid_reg;
    logic [OutDataW-1:0] out_data_reg;
    logic              advance;
    logic              in_take;

    sfs_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    sfs_step u_step (
        .cfg              (cfg),
        .state            (state_reg),
        .kind             (in_kind_reg),
        .temperature      (in_temp_reg),
        .min_cell_voltage (in_volt_reg),
        .state_next       (state_next),
        .result           (result)
    );

    assign advance       = in_valid_reg & (~out_valid_reg | m_axis_tready);
    assign s_axis_tready = ~in_valid_reg | advance;
    assign in_take       = s_axis_tvalid & s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (in_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_kind_reg <= s_axis_tuser;
            in_temp_reg <= s_axis_tdata[TempW-1:0];
            in_volt_reg <= s_axis_tdata[TempW+VoltW-1:TempW];
        end
        if (advance)
        begin
            out_data_reg <= {1'b0, result.uv_fault, result.ot_fault,
                             result.led_mode, result.led_on, result.relay_on};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    `SFS_ASSERT(a_relay_follows_state, clk, rst_n,
        advance |=> (m_axis_tdata[0] == $past(state_reg.supply_on)),
        "relay_on does not match the stored supply state")
    `SFS_ASSERT(a_steady_on_lit, clk, rst_n,
        (m_axis_tvalid && m_axis_tdata[4:2] == MODE_ON) |-> m_axis_tdata[1],
        "LED dark in steady on mode")
    `SFS_ASSERT(a_count_step, clk, rst_n,
        (state_reg.since_toggle != $past(state_reg.since_toggle)) |->
        (state_reg.since_toggle == '0 ||
         state_reg.since_toggle == $past(state_reg.since_toggle) + CountW'(1)),
        "tick counter moved by more than one")
    `SFS_ASSERT_ALWAYS(a_ready_when_empty, clk,
        (!s_axis_tready) |-> in_valid_reg,
        "input stalled with an empty input register")

endmodule

@@ dv/sfs_checker.sv @@
module sfs_checker
    import sfs_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                s_axis_tvalid,
    input  logic                s_axis_tready,
    input  logic [InDataW-1:0]  s_axis_tdata,
    input  logic                s_axis_tuser,

    input  logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    input  logic [OutDataW-1:0] m_axis_tdata,

    input  logic                cfg_we,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgDataW-1:0] cfg_data,

    output int                  errors,
    output int                  outstanding,
    output int                  results_checked
);

    typedef struct packed {
        logic      relay_on;
        logic      led_on;
        led_mode_t led_mode;
        logic      ot_fault;
        logic      uv_fault;
    } status_t;

    logic                    req_supply;
    logic signed [TempW-1:0] temp_limit;
    logic [VoltW-1:0]        volt_limit;
    logic [TimeW-1:0]        fast_time;
    logic [TimeW-1:0]        ot_on_time;
    logic [TimeW-1:0]        ot_off_time;
    logic [TimeW-1:0]        uv_on_time;
    logic [TimeW-1:0]        uv_off_time;

    logic              ot_flag;
    logic              uv_flag;
    logic              supply_on;
    logic              led_level;
    logic [CountW-1:0] ticks_since_toggle;

    status_t pending_status[$];
    int      fail_count = 0;

    assign errors = fail_count;

    task automatic check_field(input string field, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        status_t                 predicted;
        status_t                 oldest;
        status_t                 seen;
        logic signed [TempW-1:0] temp;
        logic [VoltW-1:0]        volt;
        logic [TimeW-1:0]        blink_limit;
        led_mode_t               mode;

        if (!rst_n) begin
            req_supply         = RST_SUPPLY_REQUEST;
            temp_limit         = RST_TEMP_LIMIT;
            volt_limit         = RST_MIN_VOLTAGE_LIMIT;
            fast_time          = RST_FAST_BLINK_TIME;
            ot_on_time         = RST_OVERTEMP_ON_TIME;
            ot_off_time        = RST_OVERTEMP_OFF_TIME;
            uv_on_time         = RST_UNDERVOLT_ON_TIME;
            uv_off_time        = RST_UNDERVOLT_OFF_TIME;
            ot_flag            = 1'b0;
            uv_flag            = 1'b0;
            supply_on          = 1'b0;
            led_level          = 1'b0;
            ticks_since_toggle = '0;
            pending_status.delete();
            outstanding     <= 0;
            results_checked <= 0;
        end else begin
            if (cfg_we) begin
                case (cfg_index_t'(cfg_index))
                    REG_SUPPLY_REQUEST:     req_supply  = cfg_data[0];
                    REG_TEMP_LIMIT:         temp_limit  = cfg_data[TempW-1:0];
                    REG_MIN_VOLTAGE_LIMIT:  volt_limit  = cfg_data;
                    REG_FAST_BLINK_TIME:    fast_time   = cfg_data;
                    REG_OVERTEMP_ON_TIME:   ot_on_time  = cfg_data;
                    REG_OVERTEMP_OFF_TIME:  ot_off_time = cfg_data;
                    REG_UNDERVOLT_ON_TIME:  uv_on_time  = cfg_data;
                    REG_UNDERVOLT_OFF_TIME: uv_off_time = cfg_data;
                    default: ;
                endcase
            end

            if (m_axis_tvalid && m_axis_tready) begin
                seen.relay_on = m_axis_tdata[0];
                seen.led_on   = m_axis_tdata[1];
                seen.led_mode = led_mode_t'(m_axis_tdata[4:2]);
                seen.ot_fault = m_axis_tdata[5];
                seen.uv_fault = m_axis_tdata[6];
                if (pending_status.size() == 0) begin
                    $display("%0t: result with no request waiting, expected none, actual %h",
                             $time, m_axis_tdata);
                    fail_count++;
                end else begin
                    oldest = pending_status.pop_front();
                    check_field("relay_on", oldest.relay_on, seen.relay_on);
                    check_field("led_on", oldest.led_on, seen.led_on);
                    check_field("led_mode", oldest.led_mode, seen.led_mode);
                    check_field("ot_fault", oldest.ot_fault, seen.ot_fault);
                    check_field("uv_fault", oldest.uv_fault, seen.uv_fault);
                end
                results_checked <= results_checked + 1;
            end

            if (s_axis_tvalid && s_axis_tready) begin
                temp = s_axis_tdata[TempW-1:0];
                volt = s_axis_tdata[TempW +: VoltW];
                if (!s_axis_tuser) begin
                    if (ticks_since_toggle != COUNT_MAX)
                        ticks_since_toggle = ticks_since_toggle + 1'b1;
                end else begin
                    ot_flag = temp > temp_limit;
                    uv_flag = volt < volt_limit;
                end

                // The LED follows the supply state stored before this request.
                predicted.relay_on = supply_on;
                if (supply_on)
                    mode = MODE_ON;
                else if (uv_flag)
                    mode = ot_flag ? MODE_BOTH : MODE_UNDERV;
                else
                    mode = ot_flag ? MODE_OVERT : MODE_OFF;

                case (mode)
                    MODE_ON:  led_level = 1'b1;
                    MODE_OFF: led_level = 1'b0;
                    default:
                    begin
                        if (mode == MODE_BOTH)
                            blink_limit = fast_time;
                        else if (mode == MODE_OVERT)
                            blink_limit = led_level ? ot_on_time : ot_off_time;
                        else
                            blink_limit = led_level ? uv_on_time : uv_off_time;
                        if (ticks_since_toggle > blink_limit) begin
                            led_level          = ~led_level;
                            ticks_since_toggle = '0;
                        end
                    end
                endcase

                supply_on = req_supply && !ot_flag && !uv_flag;

                predicted.led_on   = led_level;
                predicted.led_mode = mode;
                predicted.ot_fault = ot_flag;
                predicted.uv_fault = uv_flag;
                pending_status.push_back(predicted);
            end

            outstanding <= pending_status.size();
        end
    end

endmodule

@@ dv/tb.sv @@
module tb;
    import sfs_pkg::*;

    logic                clk           = 1'b0;
    logic                rst_n         = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [InDataW-1:0]  s_axis_tdata  = '0;
    logic                s_axis_tuser  = 1'b0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [OutDataW-1:0] m_axis_tdata;
    logic                cfg_we        = 1'b0;
    logic [CfgIdxW-1:0]  cfg_index     = '0;
    logic [CfgDataW-1:0] cfg_data      = '0;

    int idle_pct      = 0;
    int stall_pct     = 0;
    int hold_requests = 0;
    int holds_served  = 0;
    int hold_left     = 0;
    int requests_sent = 0;
    int temp_limit    = 70;
    int volt_limit    = 10;
    int errors;
    int outstanding;
    int results_checked;

    supply_fault_supervisor_led dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    sfs_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tuser    (s_axis_tuser),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .errors          (errors),
        .outstanding     (outstanding),
        .results_checked (results_checked)
    );

    always #4 clk = ~clk;

    // A long hold-off lets the block fill up and push back on new requests.
    always @(posedge clk) begin
        if (hold_left > 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (holds_served != hold_requests) begin
            holds_served  <= hold_requests;
            hold_left     <= 80;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= $urandom_range(99) >= stall_pct;
        end
    end

    task automatic write_reg(input cfg_index_t idx, input logic [CfgDataW-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx == REG_TEMP_LIMIT)
            temp_limit = $signed(value[TempW-1:0]);
        if (idx == REG_MIN_VOLTAGE_LIMIT)
            volt_limit = value;
    endtask

    task automatic configure(input int req, input int hot_limit, input int min_volt,
                             input int fast, input int ot_on, input int ot_off,
                             input int uv_on, input int uv_off);
        write_reg(REG_SUPPLY_REQUEST, CfgDataW'(req));
        write_reg(REG_TEMP_LIMIT, CfgDataW'(hot_limit));
        write_reg(REG_MIN_VOLTAGE_LIMIT, CfgDataW'(min_volt));
        write_reg(REG_FAST_BLINK_TIME, CfgDataW'(fast));
        write_reg(REG_OVERTEMP_ON_TIME, CfgDataW'(ot_on));
        write_reg(REG_OVERTEMP_OFF_TIME, CfgDataW'(ot_off));
        write_reg(REG_UNDERVOLT_ON_TIME, CfgDataW'(uv_on));
        write_reg(REG_UNDERVOLT_OFF_TIME, CfgDataW'(uv_off));
    endtask

    // Short times keep the LED toggling; the extremes show up now and then.
    function automatic int pick_time();
        int sel;
        sel = $urandom_range(9);
        if (sel < 7)
            return $urandom_range(12);
        else if (sel == 7)
            return 0;
        else if (sel == 8)
            return 65535;
        else
            return $urandom_range(65535);
    endfunction

    task automatic random_config();
        configure(($urandom & 32'hFFFE) | ($urandom_range(99) < 75),
                  $urandom_range(65535), $urandom_range(65535),
                  pick_time(), pick_time(), pick_time(), pick_time(), pick_time());
    endtask

    task automatic send_item(input logic kind, input logic [TempW-1:0] temp,
                             input logic [VoltW-1:0] volt);
        if ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {{(InDataW-TempW-VoltW){1'b0}}, volt, temp};
        do
            @(posedge clk);
        while (!s_axis_tready);
        requests_sent++;
    endtask

    task automatic send_random();
        int temp;
        int volt;
        case ($urandom_range(3))
            0:       temp = temp_limit - 2 + $urandom_range(4);
            1:       temp = $urandom_range(1) ? 255 : -256;
            default: temp = $urandom_range(511) - 256;
        endcase
        if (temp > 255)
            temp = 255;
        if (temp < -256)
            temp = -256;
        case ($urandom_range(3))
            0:       volt = volt_limit - 2 + $urandom_range(4);
            1:       volt = $urandom_range(1) ? 65535 : 0;
            default: volt = $urandom_range(65535);
        endcase
        if (volt > 65535)
            volt = 65535;
        if (volt < 0)
            volt = 0;
        send_item($urandom_range(99) < 30, TempW'(temp), VoltW'(volt));
    endtask

    task automatic run_random(input int count, input int hold_at);
        for (int i = 0; i < count; i++) begin
            if (i == hold_at)
                hold_requests <= hold_requests + 1;
            send_random();
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial begin
        #8000000;
        $display("tb: errors");
        $finish;
    end

    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Register defaults straight out of reset.
        send_item(1'b0, 0, 0);
        send_item(1'b1, 71, 9);
        send_item(1'b1, 70, 10);
        send_item(1'b0, 0, 0);
        drain();

        configure(1, 40, 3000, 2, 1, 0, 3, 65535);
        send_item(1'b1, 25, 3500);
        send_item(1'b0, 0, 0);
        send_item(1'b0, 9'h1FF, 16'hFFFF);
        send_item(1'b1, 255, 3500);
        repeat (4) send_item(1'b0, 0, 0);
        send_item(1'b1, 41, 3500);
        send_item(1'b1, 40, 3500);
        send_item(1'b1, -256, 0);
        repeat (5) send_item(1'b0, 0, 0);
        send_item(1'b1, 255, 0);
        repeat (4) send_item(1'b0, 0, 0);
        send_item(1'b1, 0, 65535);
        send_item(1'b1, 0, 2999);
        send_item(1'b1, 0, 3000);
        send_item(1'b0, 0, 0);
        drain();

        idle_pct  = 16;
        stall_pct = 45;
        random_config();
        run_random(100, 40);
        drain();
        random_config();
        run_random(100, 60);
        drain();

        idle_pct  = 45;
        stall_pct = 16;
        configure(0, -256, 65535, 0, 0, 0, 0, 0);
        run_random(60, -1);
        drain();
        configure(1, 255, 0, 65535, 65535, 65535, 65535, 65535);
        run_random(40, -1);
        drain();
        random_config();
        run_random(100, 50);
        drain();

        idle_pct  = 0;
        stall_pct = 0;
        random_config();
        run_random(150, 70);
        drain();

        // Clear the tick counter with a toggle, let it count in steady mode,
        // then check that a blink time equal to the count is not exceeded
        // and a lower one is.
        configure(1, 0, 1000, 0, 800, 200, 100, 900);
        send_item(1'b1, 100, 0);
        send_item(1'b0, 0, 0);
        send_item(1'b1, 0, 1000);
        repeat (60) send_item(1'b0, TempW'($urandom), VoltW'($urandom));
        drain();
        write_reg(REG_OVERTEMP_ON_TIME, 63);
        write_reg(REG_OVERTEMP_OFF_TIME, 62);
        send_item(1'b1, 100, 1000);
        repeat (3) send_item(1'b0, 0, 0);
        drain();
        write_reg(REG_OVERTEMP_ON_TIME, 62);
        repeat (3) send_item(1'b0, 0, 0);
        drain();

        $display("tb: %0d requests sent, %0d results compared", requests_sent, results_checked);
        $display("tb: covered reset defaults, register extremes, both stall mixes, long hold-offs");
        if (errors == 0 && outstanding == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+design
design/sfs_pkg.sv
design/sfs_cfg.sv
design/sfs_step.sv
design/supply_fault_supervisor_led.sv
dv/sfs_checker.sv
dv/tb.sv
